@@ rtl/core/mm4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4_pkg: shared types and constants of the 4x4 matrix multiply unit
// Element widths, accumulator sizing, item structs and the control states.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

   localparam int ELEMENT_WIDTH = 32;
   // working width never exceeds the 32-bit port
   localparam int WORK_WIDTH    = (ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32;
   localparam int PROD_WIDTH    = 2 * WORK_WIDTH;
   // four products summed need two guard bits
   localparam int ACC_WIDTH     = PROD_WIDTH + 2;
   localparam int DIM           = 4;
   localparam int IDX_WIDTH     = 2;
   localparam int CNT_WIDTH     = 4;
   localparam int FRAC_WIDTH    = 5;
   localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = FRAC_WIDTH'(16);

   localparam logic SEL_LEFT  = 1'b0;
   localparam logic SEL_RIGHT = 1'b1;

   typedef struct packed {
      logic                    matrix_select;
      logic [IDX_WIDTH-1:0]    row_index;
      logic [IDX_WIDTH-1:0]    col_index;
      logic signed [31:0]      element_value;
      logic                    go;
   } req_type;

   typedef struct packed {
      logic [IDX_WIDTH-1:0]    out_row;
      logic [IDX_WIDTH-1:0]    out_col;
      logic signed [31:0]      product_value;
      logic                    saturated;
      logic                    last;
   } rsp_type;

   // element write broadcast to every cell
   typedef struct packed {
      logic                         en;
      logic                         sel;
      logic [IDX_WIDTH-1:0]         row;
      logic [IDX_WIDTH-1:0]         col;
      logic signed [WORK_WIDTH-1:0] value;
   } wr_type;

   // partial sum travelling down the cell chain
   typedef struct packed {
      logic                        valid;
      logic [IDX_WIDTH-1:0]        row;
      logic [IDX_WIDTH-1:0]        col;
      logic                        last;
      logic signed [ACC_WIDTH-1:0] sum;
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/mm4_cell.sv @@
// ----------------------------------------------------------------------------
// mm4_cell: one multiply-accumulate cell of the product chain
// Holds column k of the left matrix and row k of the right matrix, multiplies
// the pair selected by the passing item and adds it to the partial sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [mm4_pkg::IDX_WIDTH-1:0]   cell_id,
   input  wire mm4_pkg::wr_type                 wr,
   input  wire mm4_pkg::token_type              tok_in,
   output mm4_pkg::token_type                   tok_out
);

   logic signed [mm4_pkg::WORK_WIDTH-1:0] a_ff [mm4_pkg::DIM];
   logic signed [mm4_pkg::WORK_WIDTH-1:0] a_in [mm4_pkg::DIM];
   logic signed [mm4_pkg::WORK_WIDTH-1:0] b_ff [mm4_pkg::DIM];
   logic signed [mm4_pkg::WORK_WIDTH-1:0] b_in [mm4_pkg::DIM];
   logic signed [mm4_pkg::PROD_WIDTH-1:0] prod_ff;
   logic signed [mm4_pkg::PROD_WIDTH-1:0] prod_in;
   mm4_pkg::token_type                    mid_ff;
   mm4_pkg::token_type                    out_ff;
   mm4_pkg::token_type                    out_in;

   always_comb begin
      for (int i = 0; i < mm4_pkg::DIM; i++) begin
         a_in[i] = a_ff[i];
         b_in[i] = b_ff[i];
      end
      if (wr.en && wr.sel == mm4_pkg::SEL_LEFT && wr.col == cell_id) begin
         a_in[wr.row] = wr.value;
      end
      if (wr.en && wr.sel == mm4_pkg::SEL_RIGHT && wr.row == cell_id) begin
         b_in[wr.col] = wr.value;
      end
   end

   assign prod_in = mm4_pkg::PROD_WIDTH'($signed(a_ff[tok_in.row]))
                  * mm4_pkg::PROD_WIDTH'($signed(b_ff[tok_in.col]));

   always_comb begin
      out_in     = mid_ff;
      out_in.sum = $signed(mid_ff.sum) + mm4_pkg::ACC_WIDTH'($signed(prod_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mm4_pkg::DIM; i++) begin
            a_ff[i] <= '0;
            b_ff[i] <= '0;
         end
         mid_ff <= '0;
         out_ff <= '0;
      end else begin
         for (int i = 0; i < mm4_pkg::DIM; i++) begin
            a_ff[i] <= a_in[i];
            b_ff[i] <= b_in[i];
         end
         mid_ff <= tok_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign tok_out = out_ff;

endmodule

`default_nettype wire

@@ rtl/core/mm4_ctrl.sv @@
// ----------------------------------------------------------------------------
// mm4_ctrl: product sequencer
// Walks the sixteen product positions into the cell chain after a go item and
// holds busy until the last result has left the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                launch,
   input  wire logic                done,
   output logic                     busy,
   output mm4_pkg::token_type       tok_out
);

   mm4_pkg::state_type                state_ff;
   mm4_pkg::state_type                state_in;
   logic [mm4_pkg::CNT_WIDTH-1:0]     cnt_ff;
   logic [mm4_pkg::CNT_WIDTH-1:0]     cnt_in;
   logic                              cnt_end;

   assign cnt_end = (cnt_ff == {mm4_pkg::CNT_WIDTH{1'b1}});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm4_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      busy          = 1'b1;
      tok_out       = '0;
      tok_out.row   = cnt_ff[mm4_pkg::CNT_WIDTH-1 -: mm4_pkg::IDX_WIDTH];
      tok_out.col   = cnt_ff[mm4_pkg::IDX_WIDTH-1:0];
      tok_out.last  = cnt_end;
      case (state_ff)
         mm4_pkg::ST_IDLE: begin
            busy   = 1'b0;
            cnt_in = '0;
            if (launch) begin
               state_in = mm4_pkg::ST_ISSUE;
            end
         end
         mm4_pkg::ST_ISSUE: begin
            tok_out.valid = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_end) begin
               state_in = mm4_pkg::ST_DRAIN;
            end
         end
         mm4_pkg::ST_DRAIN: begin
            // hold until the final result is out
            if (done) begin
               state_in = mm4_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mm4_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/mm4_post.sv @@
// ----------------------------------------------------------------------------
// mm4_post: result scaling
// Shifts the full-precision sum right by the fraction bits, then saturates it
// to the element range and drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_post (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [mm4_pkg::FRAC_WIDTH-1:0]    frac,
   input  wire mm4_pkg::token_type                tok_in,
   output logic                                   rsp_valid,
   output mm4_pkg::rsp_type                       rsp_item
);

   localparam int W = mm4_pkg::WORK_WIDTH;
   localparam int A = mm4_pkg::ACC_WIDTH;

   mm4_pkg::token_type              shf_ff;
   mm4_pkg::token_type              shf_in;
   logic                            valid_ff;
   mm4_pkg::rsp_type                rsp_ff;
   mm4_pkg::rsp_type                rsp_in;
   logic signed [A-1:0]             sum;
   logic [A-W:0]                    upper;
   logic                            fits;
   logic signed [W-1:0]             clipped;

   always_comb begin
      shf_in     = tok_in;
      shf_in.sum = $signed(tok_in.sum) >>> frac;
   end

   assign sum   = $signed(shf_ff.sum);
   assign upper = sum[A-1:W-1];
   assign fits  = (&upper) || !(|upper);

   always_comb begin
      if (fits) begin
         clipped = sum[W-1:0];
      end else if (sum[A-1]) begin
         clipped = {1'b1, {(W-1){1'b0}}};
      end else begin
         clipped = {1'b0, {(W-1){1'b1}}};
      end
      rsp_in.out_row       = shf_ff.row;
      rsp_in.out_col       = shf_ff.col;
      rsp_in.product_value = 32'($signed(clipped));
      rsp_in.saturated     = !fits;
      rsp_in.last          = shf_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shf_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         shf_ff   <= shf_in;
         valid_ff <= shf_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/matrix4x4_multiply_unit.sv @@
// A load item stores its element on acceptance; busy stays low and the next item may follow.
// A go item stores its element, then the first result strobes after the control
// state register, the 4-cell chain (two stages per cell) and two scaling stages;
// the rest follow one per cycle, and busy drops the cycle after the last.
// Reset clears both matrices to zero and sets fraction_bits to 16.
// ----------------------------------------------------------------------------
// matrix4x4_multiply_unit: 4x4 fixed-point matrix product engine
// Loads elements of A and B into a chain of four cells and streams A times B
// as sixteen shifted, saturated results in row-major order.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4x4_multiply_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire mm4_pkg::req_type                  req_item,
   output logic                                   rsp_valid,
   output mm4_pkg::rsp_type                       rsp_item,
   input  wire logic                              csr_we,
   input  wire logic [mm4_pkg::FRAC_WIDTH-1:0]    csr_wdata
);

   logic [mm4_pkg::FRAC_WIDTH-1:0] frac_ff;
   logic                           accept;
   logic                           done;
   mm4_pkg::wr_type                wr;
   mm4_pkg::token_type             tok [mm4_pkg::DIM+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= mm4_pkg::FRAC_RESET;
      end else if (csr_we) begin
         frac_ff <= csr_wdata;
      end
   end

   assign accept    = start && !busy;
   assign done      = rsp_valid && rsp_item.last;

   assign wr.en     = accept;
   assign wr.sel    = req_item.matrix_select;
   assign wr.row    = req_item.row_index;
   assign wr.col    = req_item.col_index;
   assign wr.value  = req_item.element_value[mm4_pkg::WORK_WIDTH-1:0];

   mm4_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .launch  (accept && req_item.go),
      .done    (done),
      .busy    (busy),
      .tok_out (tok[0])
   );

   for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_cell
      mm4_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (mm4_pkg::IDX_WIDTH'(k)),
         .wr      (wr),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   mm4_post u_post (
      .clock     (clock),
      .reset     (reset),
      .frac      (frac_ff),
      .tok_in    (tok[mm4_pkg::DIM]),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

@@ verif/tb_matrix4x4_multiply_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_multiply_unit: self-checking bench of the 4x4 matrix multiply unit
// Loads elements of both matrices, fires products, and checks every streamed
// element against a local fixed-point model, over several fraction settings.
// ----------------------------------------------------------------------------

module tb_matrix4x4_multiply_unit;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 15;
   localparam int PHASES       = 6;
   localparam logic signed [65:0] POS_LIMIT = 66'sh0_7FFF_FFFF;
   localparam logic signed [65:0] NEG_LIMIT = -POS_LIMIT - 66'sd1;
   localparam logic signed [31:0] ELEM_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] ELEM_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q16   = 32'sh0001_0000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   mm4_pkg::req_type               req_item = '0;
   logic                           rsp_valid;
   mm4_pkg::rsp_type               rsp_item;
   logic                           csr_we = 1'b0;
   logic [mm4_pkg::FRAC_WIDTH-1:0] csr_wdata = '0;

   mm4_pkg::req_type               load_queue[$];
   mm4_pkg::rsp_type               expected_products[$];
   logic signed [31:0]             left_matrix[mm4_pkg::DIM*mm4_pkg::DIM];
   logic signed [31:0]             right_matrix[mm4_pkg::DIM*mm4_pkg::DIM];
   logic [mm4_pkg::FRAC_WIDTH-1:0] frac_setting;
   int                             gap_left = 0;
   int                             burst_left = 0;
   int                             fail_count = 0;
   int                             stall_cycles = 0;

   matrix4x4_multiply_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // One element of A times B: full-precision dot product, shift, saturate.
   function automatic mm4_pkg::rsp_type matrix_product_element(int r, int c);
      mm4_pkg::rsp_type   res;
      logic signed [65:0] acc;
      logic signed [65:0] a_ext;
      logic signed [65:0] b_ext;
      logic signed [65:0] scaled;
      acc = '0;
      for (int k = 0; k < mm4_pkg::DIM; k++) begin
         a_ext = left_matrix[r * mm4_pkg::DIM + k];
         b_ext = right_matrix[k * mm4_pkg::DIM + c];
         acc = acc + a_ext * b_ext;
      end
      scaled = acc >>> frac_setting;
      res.out_row = mm4_pkg::IDX_WIDTH'(r);
      res.out_col = mm4_pkg::IDX_WIDTH'(c);
      res.last = (r == mm4_pkg::DIM - 1) && (c == mm4_pkg::DIM - 1);
      if (scaled > POS_LIMIT) begin
         res.product_value = ELEM_MAX;
         res.saturated = 1'b1;
      end else if (scaled < NEG_LIMIT) begin
         res.product_value = ELEM_MIN;
         res.saturated = 1'b1;
      end else begin
         res.product_value = scaled[31:0];
         res.saturated = 1'b0;
      end
      return res;
   endfunction

   task automatic push_item(input logic sel, input logic [mm4_pkg::IDX_WIDTH-1:0] row,
                            input logic [mm4_pkg::IDX_WIDTH-1:0] col,
                            input logic signed [31:0] value, input logic go);
      mm4_pkg::req_type item;
      item.matrix_select = sel;
      item.row_index = row;
      item.col_index = col;
      item.element_value = value;
      item.go = go;
      load_queue.push_back(item);
   endtask

   // Wait until every item is taken and every product element has arrived.
   task automatic wait_drained();
      do @(negedge clock);
      while (load_queue.size() != 0 || start || expected_products.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_fraction(input logic [mm4_pkg::FRAC_WIDTH-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Driver: hold each item until taken, then idle for a drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!start || !busy) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (load_queue.size() > 0) begin
            req_item <= load_queue.pop_front();
            start <= 1'b1;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
               gap_left <= 0;
            end else begin
               gap_left <= $urandom_range(0, 16);
               if ($urandom_range(0, 9) == 0) burst_left <= $urandom_range(8, 24);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: track stores and the register, predict on go, check results.
   always @(posedge clock) begin
      mm4_pkg::rsp_type expected;
      int               slot;
      if (reset) begin
         for (int i = 0; i < mm4_pkg::DIM * mm4_pkg::DIM; i++) begin
            left_matrix[i] = '0;
            right_matrix[i] = '0;
         end
         frac_setting = mm4_pkg::FRAC_RESET;
      end else begin
         if (csr_we) frac_setting = csr_wdata;
         if (rsp_valid) begin
            if (expected_products.size() == 0) begin
               $error("unexpected product element: row %0d col %0d value %0d",
                      rsp_item.out_row, rsp_item.out_col, rsp_item.product_value);
               fail_count++;
            end else begin
               expected = expected_products.pop_front();
               if (rsp_item.out_row !== expected.out_row) begin
                  $error("out_row: expected %0d, actual %0d",
                         expected.out_row, rsp_item.out_row);
                  fail_count++;
               end
               if (rsp_item.out_col !== expected.out_col) begin
                  $error("out_col: expected %0d, actual %0d",
                         expected.out_col, rsp_item.out_col);
                  fail_count++;
               end
               if (rsp_item.product_value !== expected.product_value) begin
                  $error("product_value: expected %0d, actual %0d",
                         expected.product_value, rsp_item.product_value);
                  fail_count++;
               end
               if (rsp_item.saturated !== expected.saturated) begin
                  $error("saturated: expected %0b, actual %0b",
                         expected.saturated, rsp_item.saturated);
                  fail_count++;
               end
               if (rsp_item.last !== expected.last) begin
                  $error("last: expected %0b, actual %0b", expected.last, rsp_item.last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            slot = req_item.row_index * mm4_pkg::DIM + req_item.col_index;
            if (req_item.matrix_select == mm4_pkg::SEL_RIGHT) begin
               right_matrix[slot] = req_item.element_value;
            end else begin
               left_matrix[slot] = req_item.element_value;
            end
            if (req_item.go) begin
               for (int r = 0; r < mm4_pkg::DIM; r++)
                  for (int c = 0; c < mm4_pkg::DIM; c++)
                     expected_products.push_back(matrix_product_element(r, c));
            end
         end
      end
   end

   // Watchdog: count cycles in which nothing moves.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [mm4_pkg::FRAC_WIDTH-1:0] frac;
      logic signed [31:0]             value;
      logic signed [19:0]             mid;
      // directed items at the reset fraction setting
      push_item(mm4_pkg::SEL_LEFT, 0, 0, 0, 1'b1);
      push_item(mm4_pkg::SEL_LEFT, 0, 0, ELEM_MAX, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 0, 0, ELEM_MAX, 1'b1);
      push_item(mm4_pkg::SEL_LEFT, 3, 3, ELEM_MIN, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 3, 3, ELEM_MAX, 1'b1);
      push_item(mm4_pkg::SEL_RIGHT, 3, 3, ELEM_MIN, 1'b1);
      push_item(mm4_pkg::SEL_LEFT, 0, 0, ONE_Q16, 1'b0);
      push_item(mm4_pkg::SEL_LEFT, 3, 3, -32'sd1, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 0, 0, ONE_Q16, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 3, 3, 32'sd1, 1'b0);
      push_item(mm4_pkg::SEL_LEFT, 1, 2, 32'shFFFD_0000, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 2, 1, 32'sh0000_8000, 1'b1);
      push_item(mm4_pkg::SEL_RIGHT, 0, 3, -32'sd1, 1'b0);
      push_item(mm4_pkg::SEL_LEFT, 2, 0, 32'sh7FFF_0000, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 0, 2, 32'sh0000_8000, 1'b1);
      push_item(mm4_pkg::SEL_LEFT, 3, 0, 32'sh5555_5555, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 3, 1, 32'shAAAA_AAAA, 1'b1);
      push_item(mm4_pkg::SEL_LEFT, 0, 3, ELEM_MIN, 1'b0);
      push_item(mm4_pkg::SEL_RIGHT, 3, 0, ELEM_MIN, 1'b1);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: frac = 0;
            1: frac = 31;
            2: frac = 8;
            3: frac = 1;
            default: frac = mm4_pkg::FRAC_WIDTH'($urandom_range(0, 31));
         endcase
         write_fraction(frac);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            mid = 20'($urandom);
            case ($urandom_range(0, 6))
               0, 1: value = $urandom;
               2: value = ELEM_MAX;
               3: value = ELEM_MIN;
               4: value = mid;
               5: value = $signed(32'($urandom_range(0, 2047))) - 32'sd1024;
               default: value = $signed(32'(1) << frac) * ($urandom_range(0, 1) ? 1 : -1);
            endcase
            push_item(1'($urandom_range(0, 1)),
                      mm4_pkg::IDX_WIDTH'($urandom_range(0, 3)),
                      mm4_pkg::IDX_WIDTH'($urandom_range(0, 3)),
                      value, $urandom_range(0, 4) == 0);
         end
      end
      // close with a product at the reset setting
      wait_drained();
      write_fraction(mm4_pkg::FRAC_RESET);
      push_item(mm4_pkg::SEL_LEFT, 1, 1, ONE_Q16, 1'b1);

      wait_drained();
      repeat (2 * DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_products.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
